// ----- rtl/core/wsfb_pkg.sv -----
// Shared types and constants for the masked WebSocket frame builder.
// No dependencies; imported by every module of the block.
package wsfb_pkg;

   localparam logic [7:0]  FrameHead     = 8'h81;
   localparam logic [7:0]  MaskBit       = 8'h80;
   localparam logic [7:0]  MediumLenByte = 8'hFE;
   localparam logic [7:0]  LongLenByte   = 8'hFF;
   localparam logic [62:0] ShortMax      = 63'd125;
   localparam logic [62:0] MediumMax     = 63'd65535;

   localparam int QDepth = 4;
   localparam int QAw    = $clog2(QDepth);

   typedef enum logic [1:0] {
      LEN_SHORT  = 2'd0,
      LEN_MEDIUM = 2'd1,
      LEN_LONG   = 2'd2
   } len_class_type;

   // One classified request: header info (first item) and the masked byte.
   typedef struct packed {
      logic          has_header;
      len_class_type len_class;
      logic          zero_len;
      logic [62:0]   len;
      logic [31:0]   mask;
      logic [7:0]    data;
      logic          last;
   } cmd_type;

   typedef enum logic [4:0] {
      S_HEAD = 5'b00001,
      S_LEN  = 5'b00010,
      S_EXT  = 5'b00100,
      S_MASK = 5'b01000,
      S_DATA = 5'b10000
   } back_state_type;

endpackage

// ----- rtl/core/websocket_masked_frame_builder.sv -----
// Masked WebSocket client frame builder. Each request carries one payload byte;
// the first request of a message also carries the 63-bit length and the mask key,
// and yields a header of 6 bytes (length up to 125), 8 bytes (up to 65535) or
// 14 bytes (longer) before its masked payload byte, one byte per cycle unless
// stalled, from the output register of the byte sequencer. Later payload bytes
// stream at one per cycle unless stalled. A four-entry command queue lets requests
// be taken while a header is still being sent. Zero-length messages give the header
// and mask only. Depends on wsfb_pkg, wsfb_front, wsfb_queue and wsfb_back.
module websocket_masked_frame_builder import wsfb_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [103:0]  req_tdata,  // payload_byte, msg_length, mask_key, zero pad
   input  logic          req_tlast,  // last_of_message
   input  logic          req_tuser,  // first_of_message
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [7:0]    rsp_tdata,  // frame_byte
   output logic          rsp_tlast   // last_of_frame
);

   logic    q_push, q_full, q_pop, q_empty;
   cmd_type q_cmd, q_head;

   wsfb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_cmd      (q_cmd)
   );

   wsfb_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .empty    (q_empty),
      .head     (q_head)
   );

   wsfb_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

`ifndef ASSERT_OFF
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full) else $error("command queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty) else $error("command queue underflow");

   a_pop_fills_output: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> rsp_tvalid) else $error("command retired without an output byte");
`endif

endmodule

// ----- rtl/core/wsfb_front.sv -----
// Front end: accepts requests, tracks message state and masks payload bytes.
// Depends on wsfb_pkg; feeds commands into wsfb_queue.
module wsfb_front import wsfb_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [103:0]  req_tdata,  // payload_byte, msg_length, mask_key, zero pad
   input  logic          req_tlast,
   input  logic          req_tuser,  // first_of_message
   input  logic          q_full,
   output logic          q_push,
   output cmd_type       q_cmd
);

   logic [31:0] held_mask_ff, held_mask_in;
   logic [1:0]  byte_phase_ff, byte_phase_in;
   logic        inside_ff, inside_in;

   logic        accept;
   logic [7:0]  pay;
   logic [62:0] len;
   logic [31:0] key;
   logic        zero;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;
   assign pay        = req_tdata[7:0];
   assign len        = req_tdata[70:8];
   assign key        = req_tdata[102:71];
   assign zero       = (len == '0);

   always_comb begin
      held_mask_in  = held_mask_ff;
      byte_phase_in = byte_phase_ff;
      inside_in     = inside_ff;
      q_push        = 1'b0;
      q_cmd         = '0;
      q_cmd.last    = req_tlast;
      q_cmd.len     = len;
      q_cmd.mask    = key;
      q_cmd.zero_len = zero;
      if (len <= ShortMax) begin
         q_cmd.len_class = LEN_SHORT;
      end else if (len <= MediumMax) begin
         q_cmd.len_class = LEN_MEDIUM;
      end else begin
         q_cmd.len_class = LEN_LONG;
      end
      if (accept && req_tuser) begin
         q_push           = 1'b1;
         q_cmd.has_header = 1'b1;
         q_cmd.data       = pay ^ key[31:24];
         held_mask_in     = key;
         byte_phase_in    = zero ? 2'd0 : 2'd1;
         inside_in        = !zero && !req_tlast;
      end else if (accept && inside_ff) begin
         q_push        = 1'b1;
         q_cmd.data    = pay ^ held_mask_ff[{~byte_phase_ff, 3'b000} +: 8];
         byte_phase_in = byte_phase_ff + 2'd1;
         inside_in     = !req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_mask_ff  <= '0;
         byte_phase_ff <= '0;
         inside_ff     <= 1'b0;
      end else begin
         held_mask_ff  <= held_mask_in;
         byte_phase_ff <= byte_phase_in;
         inside_ff     <= inside_in;
      end
   end

endmodule

// ----- rtl/core/wsfb_queue.sv -----
// Short command queue between the front end and the byte sequencer.
// Depends on wsfb_pkg for the command type and depth.
module wsfb_queue import wsfb_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    empty,
   output cmd_type head
);

   cmd_type        q_ff [QDepth];
   logic [QAw-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QAw:0]   count_ff, count_in;

   assign full  = (count_ff == (QAw+1)'(QDepth));
   assign empty = (count_ff == '0);
   assign head  = q_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (QAw+1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (QAw+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QAw'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QAw'(1);
         end
         count_ff <= count_in;
      end
   end

endmodule

// ----- rtl/core/wsfb_back.sv -----
// Back end: expands each queued command into frame bytes, one per cycle
// unless stalled, into a registered output stage. Depends on wsfb_pkg.
module wsfb_back import wsfb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        q_empty,
   input  cmd_type     q_head,
   output logic        q_pop,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,  // frame_byte
   output logic        rsp_tlast   // last_of_frame
);

   back_state_type state_ff, state_in;
   logic [2:0]     cnt_ff, cnt_in;
   logic           valid_ff, valid_in;
   logic [7:0]     byte_ff, byte_in;
   logic           last_ff, last_in;

   logic           advance;
   logic [63:0]    len64;
   logic [2:0]     ext_idx;
   logic [2:0]     ext_end;
   logic [7:0]     mask_byte;

   assign advance   = !q_empty && (!valid_ff || rsp_tready);
   assign len64     = {1'b0, q_head.len};
   assign ext_end   = (q_head.len_class == LEN_LONG) ? 3'd7 : 3'd1;
   assign ext_idx   = ext_end - cnt_ff;
   assign mask_byte = q_head.mask[{~cnt_ff[1:0], 3'b000} +: 8];

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;
      valid_in = valid_ff && !rsp_tready;
      q_pop    = 1'b0;
      if (advance) begin
         valid_in = 1'b1;
         last_in  = 1'b0;
         unique case (state_ff)
            S_HEAD: begin
               if (q_head.has_header) begin
                  byte_in  = FrameHead;
                  state_in = S_LEN;
               end else begin
                  byte_in = q_head.data;
                  last_in = q_head.last;
                  q_pop   = 1'b1;
               end
            end
            S_LEN: begin
               cnt_in = '0;
               unique case (q_head.len_class)
                  LEN_SHORT: begin
                     byte_in  = MaskBit | {1'b0, q_head.len[6:0]};
                     state_in = S_MASK;
                  end
                  LEN_MEDIUM: begin
                     byte_in  = MediumLenByte;
                     state_in = S_EXT;
                  end
                  default: begin
                     byte_in  = LongLenByte;
                     state_in = S_EXT;
                  end
               endcase
            end
            S_EXT: begin
               byte_in = len64[{ext_idx, 3'b000} +: 8];
               if (cnt_ff == ext_end) begin
                  cnt_in   = '0;
                  state_in = S_MASK;
               end else begin
                  cnt_in = cnt_ff + 3'd1;
               end
            end
            S_MASK: begin
               byte_in = mask_byte;
               if (cnt_ff[1:0] == 2'd3) begin
                  cnt_in = '0;
                  if (q_head.zero_len) begin
                     last_in  = 1'b1;
                     q_pop    = 1'b1;
                     state_in = S_HEAD;
                  end else begin
                     state_in = S_DATA;
                  end
               end else begin
                  cnt_in = cnt_ff + 3'd1;
               end
            end
            S_DATA: begin
               byte_in  = q_head.data;
               last_in  = q_head.last;
               q_pop    = 1'b1;
               state_in = S_HEAD;
            end
            default: begin
               state_in = S_HEAD;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_HEAD;
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = byte_ff;
   assign rsp_tlast  = last_ff;

endmodule

// ----- bench/tb_websocket_masked_frame_builder.sv -----
// Testbench for websocket_masked_frame_builder: drives payload requests with random gaps,
// predicts every frame byte in-line and checks the byte stream under random backpressure.
// Depends on wsfb_pkg and the websocket_masked_frame_builder RTL.
module tb_websocket_masked_frame_builder import wsfb_pkg::*;;

   localparam int ClockHalf    = 2;
   localparam int TimeLimit    = 4000000;
   localparam int DrainLimit   = 20000;
   localparam int SettleCycles = 50;
   localparam int RandomItems  = 270;

   typedef struct {
      logic [7:0] data;
      logic       last;
   } frame_byte_type;

   logic          clock;
   logic          reset      = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [103:0]  req_tdata  = '0;  // payload_byte, msg_length, mask_key, zero pad
   logic          req_tlast  = 1'b0;  // last_of_message
   logic          req_tuser  = 1'b0;  // first_of_message
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [7:0]    rsp_tdata;  // frame_byte
   logic          rsp_tlast;  // last_of_frame

   frame_byte_type frame_q[$];
   logic [31:0]    held_mask  = '0;
   logic [1:0]     byte_phase = '0;
   logic           in_message = 1'b0;

   int error_count = 0;
   int items_sent  = 0;
   int req_quiet   = 0;
   int rsp_quiet   = 0;
   int rdy_hold    = 0;

   websocket_masked_frame_builder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #ClockHalf clock = ~clock;
   end

   initial begin
      #TimeLimit;
      $display("FAIL websocket_masked_frame_builder");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      $display("ERROR @%0t: %s", $time, msg);
      error_count++;
   endtask

   // mostly no gap or a short one, a few long ones, and quiet stretches with none
   function automatic int pick_gap(inout int quiet);
      int r;
      if (quiet > 0) begin
         quiet--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 5) begin
         quiet = $urandom_range(20, 60);
         return 0;
      end
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 96) return $urandom_range(4, 8);
      return $urandom_range(15, 40);
   endfunction

   function automatic logic [7:0] mask_byte_at(input logic [1:0] phase);
      return 8'(held_mask >> (24 - 8 * phase));
   endfunction

   function automatic void push_frame_byte(input logic [7:0] data, input logic last);
      frame_byte_type fb;
      fb.data = data;
      fb.last = last;
      frame_q = {frame_q, fb};
   endfunction

   function automatic void build_frame_bytes(input logic [7:0] pay, input logic first,
                                             input logic last, input logic [62:0] len,
                                             input logic [31:0] mask);
      logic [63:0] wide_len;
      wide_len = {1'b0, len};
      if (first) begin
         held_mask  = mask;
         byte_phase = '0;
         in_message = 1'b0;
         push_frame_byte(FrameHead, 1'b0);
         if (len <= ShortMax) begin
            push_frame_byte(MaskBit | len[7:0], 1'b0);
         end else if (len <= MediumMax) begin
            push_frame_byte(MediumLenByte, 1'b0);
            push_frame_byte(len[15:8], 1'b0);
            push_frame_byte(len[7:0], 1'b0);
         end else begin
            push_frame_byte(LongLenByte, 1'b0);
            for (int i = 7; i >= 0; i--) push_frame_byte(8'(wide_len >> (8 * i)), 1'b0);
         end
         for (int i = 0; i < 4; i++)
            push_frame_byte(mask_byte_at(2'(i)), (len == 0) && (i == 3));
         if (len == 0) return;
         in_message = 1'b1;
      end
      if (!in_message) return;
      push_frame_byte(pay ^ mask_byte_at(byte_phase), last);
      byte_phase = byte_phase + 2'd1;
      if (last) in_message = 1'b0;
   endfunction

   task automatic send_item(input logic [7:0] pay, input logic first, input logic last,
                            input logic [62:0] len, input logic [31:0] mask);
      int gap;
      gap = pick_gap(req_quiet);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, mask, len, pay};
      req_tlast  <= last;
      req_tuser  <= first;
      do @(posedge clock); while (!req_tready);
      build_frame_bytes(pay, first, last, len, mask);
      items_sent++;
   endtask

   function automatic logic [62:0] rand_wide();
      logic [63:0] w;
      w = {$urandom, $urandom};
      return w[62:0];
   endfunction

   // first request carries length and mask; the rest carry noise in those fields
   task automatic send_message(input logic [62:0] len, input logic [31:0] mask,
                               input int n_items, input logic close);
      for (int k = 0; k < n_items; k++) begin
         if (k == 0)
            send_item(8'($urandom), 1'b1, close && (n_items == 1), len, mask);
         else
            send_item(8'($urandom), 1'b0, close && (k == n_items - 1), rand_wide(),
                      $urandom);
      end
   endtask

   task automatic test_short_lengths();
      send_item(8'hFF, 1'b1, 1'b1, 63'd0, 32'hFFFF_FFFF);
      send_item(8'h00, 1'b1, 1'b0, 63'd0, 32'h0000_0000);
      send_item(8'hA5, 1'b0, 1'b1, 63'd7, 32'h1234_5678);
      send_item(8'hFF, 1'b1, 1'b1, 63'd1, 32'hFFFF_FFFF);
      send_item(8'h00, 1'b1, 1'b1, 63'd1, 32'h0000_0000);
      send_message(63'd125, 32'h0000_0000, 5, 1'b1);
   endtask

   task automatic test_length_forms();
      send_message(63'd126, 32'hDEAD_BEEF, 3, 1'b1);
      send_message(63'd65535, 32'h0102_0304, 2, 1'b1);
      send_message(63'd65536, 32'hFF00_FF00, 1, 1'b1);
      send_message({63{1'b1}}, 32'h80C0_E0F0, 2, 1'b1);
   endtask

   task automatic test_abandon();
      send_message(63'd10, 32'hCAFE_F00D, 2, 1'b0);
      send_message(63'd4, 32'h5A5A_A5A5, 5, 1'b1);
      send_item(8'h3C, 1'b0, 1'b0, rand_wide(), $urandom);
   endtask

   function automatic logic [62:0] rand_length();
      int r;
      logic [62:0] len;
      r = $urandom_range(0, 99);
      if (r < 10) return 63'd0;
      if (r < 50) return 63'($urandom_range(1, 125));
      if (r < 56) begin
         case ($urandom_range(0, 3))
            0: return 63'd125;
            1: return 63'd126;
            2: return 63'd65535;
            default: return 63'd65536;
         endcase
      end
      if (r < 76) return 63'($urandom_range(126, 65535));
      do len = rand_wide(); while (len <= MediumMax);
      return len;
   endfunction

   task automatic test_random_messages();
      logic [62:0] len;
      int n_items;
      while (items_sent < RandomItems) begin
         if ($urandom_range(0, 99) < 8) begin
            send_item(8'($urandom), 1'b0, 1'($urandom_range(0, 1)), rand_wide(), $urandom);
         end else begin
            len = rand_length();
            if (len != 0 && len <= 10 && $urandom_range(0, 99) < 70)
               n_items = int'(len);
            else
               n_items = $urandom_range(1, 10);
            if (len == 0) n_items = 1;
            send_message(len, $urandom, n_items, $urandom_range(0, 99) < 90);
         end
      end
   endtask

   always @(posedge clock) begin
      int gap;
      if (rdy_hold > 0) begin
         rdy_hold--;
      end else begin
         gap = pick_gap(rsp_quiet);
         if (gap == 0) begin
            rsp_tready <= 1'b1;
            rdy_hold = $urandom_range(0, 4);
         end else begin
            rsp_tready <= 1'b0;
            rdy_hold = gap - 1;
         end
      end
   end

   always @(posedge clock) begin
      frame_byte_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (frame_q.size() == 0) begin
            report_mismatch($sformatf("unexpected byte %02h last %0b", rsp_tdata, rsp_tlast));
         end else begin
            want = frame_q.pop_front();
            if (rsp_tdata !== want.data)
               report_mismatch($sformatf("frame_byte %02h, want %02h", rsp_tdata, want.data));
            if (rsp_tlast !== want.last)
               report_mismatch($sformatf("last_of_frame %0b, want %0b (byte %02h)",
                                         rsp_tlast, want.last, want.data));
         end
      end
   end

   initial begin
      int waited;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_short_lengths();
      test_length_forms();
      test_abandon();
      test_random_messages();
      req_tvalid <= 1'b0;
      waited = 0;
      while (frame_q.size() != 0 && waited < DrainLimit) begin
         @(posedge clock);
         waited++;
      end
      repeat (SettleCycles) @(posedge clock);
      if (frame_q.size() != 0)
         report_mismatch($sformatf("%0d frame bytes never arrived", frame_q.size()));
      if (error_count == 0)
         $display("PASS websocket_masked_frame_builder");
      else
         $display("FAIL websocket_masked_frame_builder");
      $finish;
   end

endmodule
